// ----- design/plic_pkg.sv -----
package plic_pkg;

    // bus operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SIGNAL = 2'd2;

    // register map, byte offsets
    localparam logic [21:0] PEND_BASE   = 22'h001000;
    localparam logic [21:0] MEN_BASE    = 22'h002000;
    localparam logic [21:0] SEN_BASE    = 22'h002080;
    localparam logic [21:0] MTHR_ADDR   = 22'h200000;
    localparam logic [21:0] MCLAIM_ADDR = 22'h200004;
    localparam logic [21:0] STHR_ADDR   = 22'h201000;
    localparam logic [21:0] SCLAIM_ADDR = 22'h201004;

    // control from the sequencer to the arbiter
    typedef struct packed {
        logic start;   // load thresholds, clear winners
        logic step;    // compare the source on the ram read port
    } t_arb_ctl;

    // hit on a two-word bit region; word select is the low word address bit
    function automatic logic region_hit(logic [19:0] word_addr, logic [21:0] base);
        region_hit = (word_addr[19:1] == base[21:3]);
    endfunction

endpackage

// ----- design/platform_interrupt_controller.sv -----
// Interrupt controller for one hart with a machine and a supervisor context.
// Each input word is a bus read, a bus write or a source signal; each gives
// one output word with the read data and both interrupt lines as they stand
// after it. Source priorities live in a small ram with one write and one
// registered read port and are walked one source per cycle through one
// arbiter. A priority read fetches the ram entry before the walk, and a
// claim read walks the sources once to pick the winner and once more for
// the lines. The output register lets the next word be accepted while a
// result waits to be taken.
module platform_interrupt_controller #(
    parameter int NUM_SOURCES   = 32,
    parameter int PRIORITY_BITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [21:0] i_addr,
    input  logic [31:0] i_wdata,
    input  logic [4:0]  i_source,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_rdata,
    output logic        o_irq_machine,
    output logic        o_irq_supervisor
);

    localparam int IW = $clog2(NUM_SOURCES);
    localparam int CW = IW + 1;
    localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};
    localparam logic WIDE = (NUM_SOURCES > 32);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_PRD   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_POST  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [1:0]               r_op, n_op;
    logic [19:0]              r_aw, n_aw;
    logic [31:0]              r_wdata, n_wdata;
    logic [4:0]               r_source, n_source;
    logic [NUM_SOURCES-1:0]   r_pend, n_pend;
    logic [NUM_SOURCES-1:0]   r_isrv, n_isrv;
    logic [NUM_SOURCES-1:0]   r_en_m, n_en_m;
    logic [NUM_SOURCES-1:0]   r_en_s, n_en_s;
    logic [PRIORITY_BITS-1:0] r_thr_m, n_thr_m;
    logic [PRIORITY_BITS-1:0] r_thr_s, n_thr_s;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]            r_cmp_id, n_cmp_id;
    logic                     r_claim, n_claim;
    logic                     r_ctx_s, n_ctx_s;
    logic [31:0]              r_res_rdata, n_res_rdata;
    logic                     r_res_irq_m, n_res_irq_m;
    logic                     r_res_irq_s, n_res_irq_s;
    logic                     r_out_valid, n_out_valid;
    logic [31:0]              r_out_rdata, n_out_rdata;
    logic                     r_out_irq_m, n_out_irq_m;
    logic                     r_out_irq_s, n_out_irq_s;

    plic_pkg::t_arb_ctl       arb_ctl;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    logic [PRIORITY_BITS-1:0] mem_wdata;
    logic [IW-1:0]            mem_raddr;
    logic [PRIORITY_BITS-1:0] mem_rdata;
    logic [IW-1:0]            best_m;
    logic [IW-1:0]            best_s;
    logic [IW-1:0]            claim_id;
    logic                     scan_go;

    // address decode of the held word
    logic          prio_hit, prio_ok, pend_hit, men_hit, sen_hit;
    logic          mthr_hit, sthr_hit, mclaim_hit, sclaim_hit;
    logic [IW-1:0] prio_idx;
    logic [63:0]   pend64, en_m64, en_s64;
    logic [31:0]   rd_word;
    logic [63:0]   wr_m64, wr_s64;
    logic          cmp_ok, sig_ok;
    logic [IW-1:0] cmp_id, sig_id;

    assign prio_hit   = (r_aw < 20'h00400);
    assign prio_ok    = (r_aw != '0) && (r_aw < 20'(NUM_SOURCES));
    assign prio_idx   = IW'(r_aw);
    assign pend_hit   = plic_pkg::region_hit(r_aw, plic_pkg::PEND_BASE) && (!r_aw[0] || WIDE);
    assign men_hit    = plic_pkg::region_hit(r_aw, plic_pkg::MEN_BASE) && (!r_aw[0] || WIDE);
    assign sen_hit    = plic_pkg::region_hit(r_aw, plic_pkg::SEN_BASE) && (!r_aw[0] || WIDE);
    assign mthr_hit   = (r_aw == plic_pkg::MTHR_ADDR[21:2]);
    assign sthr_hit   = (r_aw == plic_pkg::STHR_ADDR[21:2]);
    assign mclaim_hit = (r_aw == plic_pkg::MCLAIM_ADDR[21:2]);
    assign sclaim_hit = (r_aw == plic_pkg::SCLAIM_ADDR[21:2]);

    assign pend64 = 64'(r_pend);
    assign en_m64 = 64'(r_en_m);
    assign en_s64 = 64'(r_en_s);

    // read data for the plain registers
    always_comb begin
        rd_word = '0;
        if (pend_hit) begin
            rd_word = r_aw[0] ? pend64[63:32] : pend64[31:0];
        end else if (men_hit) begin
            rd_word = r_aw[0] ? en_m64[63:32] : en_m64[31:0];
        end else if (sen_hit) begin
            rd_word = r_aw[0] ? en_s64[63:32] : en_s64[31:0];
        end else if (mthr_hit) begin
            rd_word = 32'(r_thr_m);
        end else if (sthr_hit) begin
            rd_word = 32'(r_thr_s);
        end
    end

    // enable word merge
    assign wr_m64 = r_aw[0] ? {r_wdata, en_m64[31:0]} : {en_m64[63:32], r_wdata};
    assign wr_s64 = r_aw[0] ? {r_wdata, en_s64[31:0]} : {en_s64[63:32], r_wdata};

    // complete and gateway checks
    assign cmp_ok = (r_wdata != '0) && (r_wdata < 32'(NUM_SOURCES));
    assign cmp_id = IW'(r_wdata);
    assign sig_ok = (r_source != '0) && (32'(r_source) < 32'(NUM_SOURCES));
    assign sig_id = IW'(r_source);

    assign claim_id = r_ctx_s ? best_s : best_m;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_aw        = r_aw;
        n_wdata     = r_wdata;
        n_source    = r_source;
        n_pend      = r_pend;
        n_isrv      = r_isrv;
        n_en_m      = r_en_m;
        n_en_s      = r_en_s;
        n_thr_m     = r_thr_m;
        n_thr_s     = r_thr_s;
        n_cnt       = r_cnt;
        n_cmp_vld   = 1'b0;
        n_cmp_id    = r_cmp_id;
        n_claim     = r_claim;
        n_ctx_s     = r_ctx_s;
        n_res_rdata = r_res_rdata;
        n_res_irq_m = r_res_irq_m;
        n_res_irq_s = r_res_irq_s;
        n_out_valid = r_out_valid;
        n_out_rdata = r_out_rdata;
        n_out_irq_m = r_out_irq_m;
        n_out_irq_s = r_out_irq_s;
        arb_ctl     = '0;
        mem_we      = 1'b0;
        mem_waddr   = prio_idx;
        mem_wdata   = r_wdata[PRIORITY_BITS-1:0];
        mem_raddr   = prio_idx;
        scan_go     = 1'b0;

        // output word taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_op;
                    n_aw     = i_addr[21:2];
                    n_wdata  = i_wdata;
                    n_source = i_source;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_rdata = '0;
                n_claim     = 1'b0;
                scan_go     = 1'b1;
                case (r_op)
                    plic_pkg::OP_READ: begin
                        if (prio_hit) begin
                            if (prio_ok) begin
                                scan_go = 1'b0;
                                n_state = S_PRD;
                            end
                        end else if (mclaim_hit || sclaim_hit) begin
                            n_claim = 1'b1;
                            n_ctx_s = sclaim_hit;
                        end else begin
                            n_res_rdata = rd_word;
                        end
                    end
                    plic_pkg::OP_WRITE: begin
                        if (prio_hit) begin
                            mem_we = prio_ok;
                        end else if (men_hit) begin
                            n_en_m = NUM_SOURCES'(wr_m64) & SRC_MASK;
                        end else if (sen_hit) begin
                            n_en_s = NUM_SOURCES'(wr_s64) & SRC_MASK;
                        end else if (mthr_hit) begin
                            n_thr_m = r_wdata[PRIORITY_BITS-1:0];
                        end else if (sthr_hit) begin
                            n_thr_s = r_wdata[PRIORITY_BITS-1:0];
                        end else if (mclaim_hit) begin
                            if (cmp_ok && r_en_m[cmp_id]) begin
                                n_isrv[cmp_id] = 1'b0;
                            end
                        end else if (sclaim_hit) begin
                            if (cmp_ok && r_en_s[cmp_id]) begin
                                n_isrv[cmp_id] = 1'b0;
                            end
                        end
                    end
                    plic_pkg::OP_SIGNAL: begin
                        if (sig_ok && !r_isrv[sig_id]) begin
                            n_pend[sig_id] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PRD: begin
                n_res_rdata = 32'(mem_rdata);
                scan_go     = 1'b1;
            end
            S_SCAN: begin
                mem_raddr = r_cnt[IW-1:0];
                n_cmp_vld = 1'b1;
                n_cmp_id  = r_cnt[IW-1:0];
                n_cnt     = r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_SOURCES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (r_claim) begin
                    // claim answers with the winner, then the lines are rescanned
                    n_res_rdata = 32'(claim_id);
                    if (claim_id != '0) begin
                        n_pend[claim_id] = 1'b0;
                        n_isrv[claim_id] = 1'b1;
                    end
                    n_claim = 1'b0;
                    scan_go = 1'b1;
                end else begin
                    n_res_irq_m = (best_m != '0);
                    n_res_irq_s = (best_s != '0);
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_rdata = r_res_rdata;
                    n_out_irq_m = r_res_irq_m;
                    n_out_irq_s = r_res_irq_s;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start a walk over sources one to the top
        if (scan_go) begin
            n_state       = S_SCAN;
            n_cnt         = CW'(1);
            arb_ctl.start = 1'b1;
        end
        arb_ctl.step = r_cmp_vld;
    end

    // control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_isrv      <= '0;
            r_en_m      <= '0;
            r_en_s      <= '0;
            r_thr_m     <= '0;
            r_thr_s     <= '0;
            r_cmp_vld   <= 1'b0;
            r_claim     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_rdata <= '0;
            r_out_irq_m <= 1'b0;
            r_out_irq_s <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_isrv      <= n_isrv;
            r_en_m      <= n_en_m;
            r_en_s      <= n_en_s;
            r_thr_m     <= n_thr_m;
            r_thr_s     <= n_thr_s;
            r_cmp_vld   <= n_cmp_vld;
            r_claim     <= n_claim;
            r_out_valid <= n_out_valid;
            r_out_rdata <= n_out_rdata;
            r_out_irq_m <= n_out_irq_m;
            r_out_irq_s <= n_out_irq_s;
        end
    end

    // held word and working payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_aw        <= n_aw;
        r_wdata     <= n_wdata;
        r_source    <= n_source;
        r_cnt       <= n_cnt;
        r_cmp_id    <= n_cmp_id;
        r_ctx_s     <= n_ctx_s;
        r_res_rdata <= n_res_rdata;
        r_res_irq_m <= n_res_irq_m;
        r_res_irq_s <= n_res_irq_s;
    end

    plic_prio_ram #(
        .DEPTH (NUM_SOURCES),
        .WIDTH (PRIORITY_BITS)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // thresholds come from the next-value side so a threshold write counts in its own walk
    plic_arb #(
        .NUM_SOURCES   (NUM_SOURCES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_arb (
        .i_clk    (i_clk),
        .i_ctl    (arb_ctl),
        .i_id     (r_cmp_id),
        .i_prio   (mem_rdata),
        .i_pend   (r_pend),
        .i_en_m   (r_en_m),
        .i_en_s   (r_en_s),
        .i_thr_m  (n_thr_m),
        .i_thr_s  (n_thr_s),
        .o_best_m (best_m),
        .o_best_s (best_s)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_rdata          = r_out_rdata;
    assign o_irq_machine    = r_out_irq_m;
    assign o_irq_supervisor = r_out_irq_s;

endmodule

// ----- design/plic_prio_ram.sv -----
module plic_prio_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;

    // storage array, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // per-entry written flags, an unwritten entry reads as zero priority
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ----- design/plic_arb.sv -----
module plic_arb #(
    parameter int NUM_SOURCES   = 32,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                             i_clk,
    input  plic_pkg::t_arb_ctl               i_ctl,
    input  logic [$clog2(NUM_SOURCES)-1:0]   i_id,
    input  logic [PRIORITY_BITS-1:0]         i_prio,
    input  logic [NUM_SOURCES-1:0]           i_pend,
    input  logic [NUM_SOURCES-1:0]           i_en_m,
    input  logic [NUM_SOURCES-1:0]           i_en_s,
    input  logic [PRIORITY_BITS-1:0]         i_thr_m,
    input  logic [PRIORITY_BITS-1:0]         i_thr_s,
    output logic [$clog2(NUM_SOURCES)-1:0]   o_best_m,
    output logic [$clog2(NUM_SOURCES)-1:0]   o_best_s
);

    localparam int IW = $clog2(NUM_SOURCES);

    logic [PRIORITY_BITS-1:0] r_bp_m;
    logic [PRIORITY_BITS-1:0] r_bp_s;
    logic [IW-1:0]            r_bid_m;
    logic [IW-1:0]            r_bid_s;
    logic                     cand_m;
    logic                     cand_s;

    assign cand_m = i_pend[i_id] & i_en_m[i_id];
    assign cand_s = i_pend[i_id] & i_en_s[i_id];

    // running winner per context, strict compare keeps the lowest id on ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_bp_m  <= i_thr_m;
            r_bp_s  <= i_thr_s;
            r_bid_m <= '0;
            r_bid_s <= '0;
        end else if (i_ctl.step) begin
            if (cand_m && (i_prio > r_bp_m)) begin
                r_bp_m  <= i_prio;
                r_bid_m <= i_id;
            end
            if (cand_s && (i_prio > r_bp_s)) begin
                r_bp_s  <= i_prio;
                r_bid_s <= i_id;
            end
        end
    end

    assign o_best_m = r_bid_m;
    assign o_best_s = r_bid_s;

endmodule

// ----- design/plic_chk.sv -----
module plic_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_rdata,
    input logic        o_irq_machine,
    input logic        o_irq_supervisor
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // an accepted word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a word was accepted");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rdata)
            && $stable(o_irq_machine) && $stable(o_irq_supervisor))
        else $error("stalled output word changed");

    // interrupt lines move only with a new output word
    a_irq_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_irq_machine) || !$stable(o_irq_supervisor) |-> o_out_valid)
        else $error("interrupt line changed without an output word");

endmodule

bind platform_interrupt_controller plic_chk u_plic_chk (.*);
